// ===== src/bar_pkg.sv =====
// Shared types and constants for the button auto-repeat block.
`default_nettype none

package bar_pkg;

  localparam int unsigned ButtonsW = 19;
  localparam int unsigned ElapsedW = 12;
  localparam int unsigned RegW     = 14;
  localparam int unsigned CdW      = 16;
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgInitialDelay = 2'd0,
    CfgRepeatPeriod = 2'd1
  } cfg_reg_e;

  localparam logic [RegW-1:0] DelayReset  = 14'd400;
  localparam logic [RegW-1:0] PeriodReset = 14'd50;

  localparam logic signed [CdW-1:0] CdMin = 16'sh8000;
  localparam logic signed [CdW-1:0] CdMax = 16'sd16383;

  typedef logic signed [CdW-1:0] countdown_t;

endpackage

`default_nettype wire

// ===== src/button_auto_repeat_core.sv =====
// Button auto-repeat core: press edges plus typematic repeat events per poll.
//
// Input channel: one item per poll, the debounced button mask and the
// milliseconds since the previous poll; accepted when in_valid_i is high and
// in_stall_o is low. Output channel: one item per input item, the mask of
// new presses ORed with repeat events; taken when out_valid_o is high and
// out_stall_i is low.
// Each accepted item is registered in the input register, then moves to the
// result register. Throughput: one item per cycle unless the output stalls;
// each button lane is one saturating subtract, one compare and one add
// between the input and result registers. The input register keeps taking
// items while a result waits, as long as the item ahead of it can move into
// the result register. Reset clears both valid flags and the previous mask,
// loads every countdown with 400, the initial delay with 400 and the repeat
// period with 50. Configuration writes are registered; a written 0 is kept as 1.
// When the receiver stalls, the result holds, one more item is buffered in
// the input register, then in_stall_o rises.
`default_nettype none

module button_auto_repeat_core #(
  parameter int unsigned BUTTON_COUNT = 19
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [bar_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire  [bar_pkg::RegW-1:0]         cfg_data_i,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [bar_pkg::ButtonsW-1:0]     buttons_now_i,
  input  wire  [bar_pkg::ElapsedW-1:0]     elapsed_ms_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [bar_pkg::ButtonsW-1:0]     press_events_o
);
  import bar_pkg::*;

  localparam int unsigned NumLanes = (BUTTON_COUNT < ButtonsW) ? BUTTON_COUNT : ButtonsW;
  localparam logic [ButtonsW-1:0] LaneMask = ButtonsW'((33'd1 << NumLanes) - 33'd1);

  logic [RegW-1:0]     delay_q, period_q;
  logic                in_valid_q;
  logic [ButtonsW-1:0] in_buttons_q;
  logic [ElapsedW-1:0] in_elapsed_q;
  logic                out_valid_q;
  logic [ButtonsW-1:0] press_q, press_d;
  logic [ButtonsW-1:0] prev_q, now_masked;
  countdown_t          cd_q [NumLanes];
  countdown_t          cd_d [NumLanes];
  countdown_t          lane_c [NumLanes];
  logic signed [CdW:0] lane_dec [NumLanes];
  logic [ButtonsW-1:0] repeats;
  logic                out_ready, move, in_take;
  logic [RegW-1:0]     cfg_val;
  logic                cd_bad;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign move       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;
  assign cfg_val    = (cfg_data_i == '0) ? RegW'(1) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q  <= DelayReset;
      period_q <= PeriodReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgInitialDelay: delay_q  <= cfg_val;
        CfgRepeatPeriod: period_q <= cfg_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (move) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_buttons_q <= buttons_now_i;
      in_elapsed_q <= elapsed_ms_i;
    end
  end

  assign now_masked = in_buttons_q & LaneMask;

  always_comb begin
    repeats = '0;
    for (int i = 0; i < NumLanes; i++) begin
      lane_dec[i] = {cd_q[i][CdW-1], cd_q[i]}
                  - $signed({{(CdW + 1 - ElapsedW){1'b0}}, in_elapsed_q});
      if (now_masked[i]) begin
        lane_c[i] = (lane_dec[i] < $signed({CdMin[CdW-1], CdMin})) ? CdMin
                                                                   : lane_dec[i][CdW-1:0];
      end else begin
        lane_c[i] = $signed({{(CdW - RegW){1'b0}}, delay_q});
      end
      if (lane_c[i] <= $signed(CdW'(0))) begin
        cd_d[i]    = lane_c[i] + $signed({{(CdW - RegW){1'b0}}, period_q});
        repeats[i] = 1'b1;
      end else begin
        cd_d[i] = lane_c[i];
      end
    end
  end

  assign press_d = ((now_masked & ~prev_q) | repeats) & LaneMask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumLanes; i++) begin
        cd_q[i] <= $signed({{(CdW - RegW){1'b0}}, DelayReset});
      end
    end else begin
      if (move) begin
        prev_q      <= now_masked;
        out_valid_q <= 1'b1;
        for (int i = 0; i < NumLanes; i++) begin
          cd_q[i] <= cd_d[i];
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      press_q <= press_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign press_events_o = press_q;

  always_comb begin
    cd_bad = 1'b0;
    for (int i = 0; i < NumLanes; i++) begin
      if (cd_q[i] > CdMax || cd_q[i] == CdMin) begin
        cd_bad = 1'b1;
      end
    end
  end

  // countdowns stay between one above the floor and the largest register value
  a_cd_range: assert property (@(posedge clk_i) disable iff (!rst_ni) !cd_bad)
    else $error("countdown out of range");

  a_regs_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    delay_q != '0 && period_q != '0)
    else $error("timing register holds zero");

  // an event is only ever raised for a button held in the same poll
  a_events_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (press_q & ~prev_q) == '0)
    else $error("event for a released button");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("input stalled with no item held");

  a_item_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_valid_q |=> out_valid_q)
    else $error("buffered item did not reach result register");

endmodule

`default_nettype wire
